>>> hdl/dlms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlms_pkg
// Shared constants, types and helpers for the digit / LED / dot-matrix scanner.
// ----------------------------------------------------------------------------
package dlms_pkg;

  // Sizing
  localparam int IMAGE_DEPTH = 64;   // 16 .. 256
  localparam int DIGIT_COUNT = 6;    // 1 .. 7
  localparam int IMG_AW      = $clog2(IMAGE_DEPTH);
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int SUM_W       = 9;    // holds offset + row and any depth up to 256

  localparam logic [2:0]       DIGIT_LAST = 3'(DIGIT_COUNT);
  localparam logic [SUM_W-1:0] DEPTH_S    = SUM_W'(IMAGE_DEPTH);

  // Field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int TPS_W   = 10;
  localparam int RPS_W   = 6;
  localparam int SCR_W   = 6;
  localparam int LINE_W  = 3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_FAST  = 2'd0;
  localparam logic [OP_W-1:0] OP_SLOW  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // Bank select codes
  localparam logic BANK_MATRIX = 1'b0;
  localparam logic BANK_DIGIT  = 1'b1;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_TICKS_PER_SEC  = 2'd0;
  localparam logic [1:0] REG_REFRESH_PER_SC = 2'd1;
  localparam logic [1:0] REG_SCROLL_POS     = 2'd2;

  localparam logic [TPS_W-1:0] TPS_RESET = 10'd1000;
  localparam logic [RPS_W-1:0] RPS_RESET = 6'd50;
  localparam logic [SCR_W-1:0] SCR_RESET = 6'd32;

  localparam logic [BYTE_W-1:0] BLANK = 8'hFF;

  typedef struct packed {
    logic              bank;
    logic [LINE_W-1:0] line;
    logic [BYTE_W-1:0] pattern;
  } line_res_t;

  // Common-anode seven-segment code; out-of-range digits show as nine
  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] d);
    logic [BYTE_W-1:0] c;
    case (d)
      4'd0:    c = 8'hC0;
      4'd1:    c = 8'hF9;
      4'd2:    c = 8'hA4;
      4'd3:    c = 8'hB0;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h92;
      4'd6:    c = 8'h82;
      4'd7:    c = 8'hF8;
      4'd8:    c = 8'h80;
      default: c = 8'h90;
    endcase
    return c;
  endfunction

endpackage : dlms_pkg
`default_nettype wire

>>> hdl/dlms_image_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlms_image_ram
// Dot-matrix image store: one write port, one registered read port.
// Entries never written read back as all ones.
// ----------------------------------------------------------------------------
module dlms_image_ram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [dlms_pkg::IMG_AW-1:0] wr_addr,
  input  wire logic [dlms_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [dlms_pkg::IMG_AW-1:0] rd_addr,
  output logic      [dlms_pkg::BYTE_W-1:0] rd_data
);
  import dlms_pkg::*;

  logic [BYTE_W-1:0]      img_mem_r [IMAGE_DEPTH];
  logic [IMAGE_DEPTH-1:0] vld_r;
  logic [BYTE_W-1:0]      rdata_r;
  logic                   rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      img_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= img_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : BLANK;

endmodule : dlms_image_ram
`default_nettype wire

>>> hdl/dlms_digit_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlms_digit_scan
// Digit/LED bank: line scan, seconds prescaler, BCD count and running light.
// The line for a tick is taken from the state before that tick.
// ----------------------------------------------------------------------------
module dlms_digit_scan (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       tick,
  input  wire logic [dlms_pkg::TPS_W-1:0] ticks_per_sec,
  output dlms_pkg::line_res_t             res
);
  import dlms_pkg::*;

  logic [LINE_W-1:0] digit_line_r, digit_line_nxt;
  logic [TPS_W-1:0]  tick_count_r, tick_count_nxt;
  logic [BCD_W-1:0]  seconds_bcd_r, seconds_bcd_nxt;
  logic              digits_shown_r;
  logic [BYTE_W-1:0] led_byte_r;
  logic [2:0]        led_next_r;

  logic [TPS_W-1:0]  tick_inc;
  logic              sec_hit;
  logic [BYTE_W-1:0] digit_pat;
  logic [3:0]        dig;
  logic              carry;

  // Prescaler; a zero period wraps at the counter width
  always_comb begin
    tick_inc       = tick_count_r + TPS_W'(1);
    sec_hit        = (ticks_per_sec == '0) ? (tick_inc == '0) : (tick_inc >= ticks_per_sec);
    tick_count_nxt = sec_hit ? '0 : tick_inc;
  end

  // BCD ripple increment
  always_comb begin
    seconds_bcd_nxt = '0;
    carry           = 1'b1;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      dig = seconds_bcd_r[4*k +: 4] + {3'b000, carry};
      if (dig >= 4'd10) begin
        dig   = 4'd0;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      seconds_bcd_nxt[4*k +: 4] = dig;
    end
  end

  always_comb begin
    digit_pat = BLANK;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (digit_line_r == LINE_W'(k)) begin
        digit_pat = seg_code(seconds_bcd_r[4*k +: 4]);
      end
    end
  end

  always_comb begin
    digit_line_nxt = (digit_line_r >= DIGIT_LAST) ? '0 : digit_line_r + LINE_W'(1);
    res.bank       = BANK_DIGIT;
    res.line       = digit_line_r;
    if (digit_line_r >= DIGIT_LAST) begin
      res.pattern = led_byte_r;
    end else if (digits_shown_r) begin
      res.pattern = digit_pat;
    end else begin
      res.pattern = BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_line_r   <= '0;
      tick_count_r   <= '0;
      seconds_bcd_r  <= '0;
      digits_shown_r <= 1'b0;
      led_byte_r     <= BLANK;
      led_next_r     <= '0;
    end else if (tick) begin
      digit_line_r <= digit_line_nxt;
      tick_count_r <= tick_count_nxt;
      if (sec_hit) begin
        seconds_bcd_r  <= seconds_bcd_nxt;
        digits_shown_r <= 1'b1;
        led_byte_r     <= ~(BYTE_W'(1) << led_next_r);
        led_next_r     <= led_next_r + 3'd1;
      end
    end
  end

endmodule : dlms_digit_scan
`default_nettype wire

>>> hdl/dlms_matrix_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlms_matrix_scan
// Dot-matrix row scan and scroll window; forms the image read address.
// ----------------------------------------------------------------------------
module dlms_matrix_scan (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        tick,
  input  wire logic [dlms_pkg::RPS_W-1:0]  refreshes_per_scroll,
  input  wire logic [dlms_pkg::SCR_W-1:0]  scroll_positions,
  output logic      [dlms_pkg::LINE_W-1:0] row,
  output logic      [dlms_pkg::IMG_AW-1:0] rd_addr
);
  import dlms_pkg::*;

  logic [LINE_W-1:0] row_r;
  logic [SCR_W-1:0]  scroll_r, scroll_nxt;
  logic [RPS_W-1:0]  refresh_r, refresh_nxt;

  logic [RPS_W-1:0]  ref_inc;
  logic              ref_hit;
  logic [SCR_W-1:0]  scr_inc;
  logic              scr_hit;
  logic [SUM_W-1:0]  addr_sum;

  always_comb begin
    ref_inc     = refresh_r + RPS_W'(1);
    ref_hit     = (refreshes_per_scroll == '0) ? (ref_inc == '0)
                                               : (ref_inc >= refreshes_per_scroll);
    refresh_nxt = ref_hit ? '0 : ref_inc;

    scr_inc = scroll_r + SCR_W'(1);
    scr_hit = (scroll_positions == '0) ? (scr_inc == '0) : (scr_inc >= scroll_positions);
    if (ref_hit) begin
      scroll_nxt = scr_hit ? '0 : scr_inc;
    end else begin
      scroll_nxt = scroll_r;
    end
  end

  // Window wraps around the image depth; a few compare-subtract steps suffice
  always_comb begin
    addr_sum = SUM_W'(scroll_r) + SUM_W'(row_r);
    for (int k = 0; k < 5; k++) begin
      if (addr_sum >= DEPTH_S) begin
        addr_sum = addr_sum - DEPTH_S;
      end
    end
  end

  assign row     = row_r;
  assign rd_addr = IMG_AW'(addr_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      scroll_r  <= '0;
      refresh_r <= '0;
    end else if (tick) begin
      row_r     <= row_r + LINE_W'(1);
      scroll_r  <= scroll_nxt;
      refresh_r <= refresh_nxt;
    end
  end

endmodule : dlms_matrix_scan
`default_nettype wire

>>> hdl/digit_led_matrix_scan_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// digit_led_matrix_scan_controller
// Scan controller for a six-digit seven-segment display, an LED row and an
// 8-row dot matrix whose image window scrolls.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request goes through the image read stage (stage 1), then
//   the output register, which offers its result.
// Throughput: one request per cycle; a request waits only while stage 1 holds a line
//   behind a stalled output register.
// Reset: synchronous, active low; clears counters, registers to their defaults and the
//   image valid bits at once, so the image reads as all ones with no clearing pass.
module digit_led_matrix_scan_controller (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [dlms_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [dlms_pkg::ADDR_W-1:0]  in_image_address,
  input  wire logic [dlms_pkg::BYTE_W-1:0]  in_image_data,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_bank_select,
  output logic      [dlms_pkg::LINE_W-1:0]  out_line_select,
  output logic      [dlms_pkg::BYTE_W-1:0]  out_pattern,
  // configuration
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [dlms_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [dlms_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic      [dlms_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import dlms_pkg::*;

  logic [TPS_W-1:0] tps_r;
  logic [RPS_W-1:0] rps_r;
  logic [SCR_W-1:0] scr_r;
  logic             cfg_wr;

  logic             accept, fast_tick, slow_tick, img_wr;
  logic             out_free, s1_move;

  line_res_t        digit_res;
  logic [LINE_W-1:0] mx_row;
  logic [IMG_AW-1:0] mx_addr;
  logic [BYTE_W-1:0] img_rdata;

  logic              s1_valid_r;
  logic              s1_mem_r;
  line_res_t         s1_res_r;
  logic              out_valid_r;
  line_res_t         out_res_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      rps_r <= RPS_RESET;
      scr_r <= SCR_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TICKS_PER_SEC:  tps_r <= cfg_pwdata[TPS_W-1:0];
        REG_REFRESH_PER_SC: rps_r <= cfg_pwdata[RPS_W-1:0];
        REG_SCROLL_POS:     scr_r <= cfg_pwdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TICKS_PER_SEC:  cfg_prdata = PDATA_W'(tps_r);
      REG_REFRESH_PER_SC: cfg_prdata = PDATA_W'(rps_r);
      REG_SCROLL_POS:     cfg_prdata = PDATA_W'(scr_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Handshake: stage 1 moves whenever the output register is free or draining
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;
  assign fast_tick = accept && (in_opcode == OP_FAST);
  assign slow_tick = accept && (in_opcode == OP_SLOW);
  assign img_wr    = accept && (in_opcode == OP_WRITE) &&
                     (SUM_W'(in_image_address) < DEPTH_S);

  dlms_digit_scan u_digit (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (fast_tick),
    .ticks_per_sec (tps_r),
    .res           (digit_res)
  );

  dlms_matrix_scan u_matrix (
    .clk                  (clk),
    .rst_n                (rst_n),
    .tick                 (slow_tick),
    .refreshes_per_scroll (rps_r),
    .scroll_positions     (scr_r),
    .row                  (mx_row),
    .rd_addr              (mx_addr)
  );

  // Read data holds until the next slow tick, which cannot be accepted while stage 1 stalls
  dlms_image_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (img_wr),
    .wr_addr (IMG_AW'(in_image_address)),
    .wr_data (in_image_data),
    .rd_en   (slow_tick),
    .rd_addr (mx_addr),
    .rd_data (img_rdata)
  );

  // Stage 1: waits for the image read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (fast_tick || slow_tick) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_tick) begin
      s1_mem_r <= 1'b0;
      s1_res_r <= digit_res;
    end else if (slow_tick) begin
      s1_mem_r         <= 1'b1;
      s1_res_r.bank    <= BANK_MATRIX;
      s1_res_r.line    <= mx_row;
      s1_res_r.pattern <= BLANK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r.bank    <= s1_res_r.bank;
      out_res_r.line    <= s1_res_r.line;
      out_res_r.pattern <= s1_mem_r ? img_rdata : s1_res_r.pattern;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bank_select = out_res_r.bank;
  assign out_line_select = out_res_r.line;
  assign out_pattern     = out_res_r.pattern;

endmodule : digit_led_matrix_scan_controller
`default_nettype wire

>>> dv/tb_digit_led_matrix_scan_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_digit_led_matrix_scan_controller
// Self-checking bench for the digit / LED / dot-matrix scan controller. A
// scoreboard class tracks the scan state (seconds count, LED light, matrix
// window, image bytes) and predicts each line the block drives. The bench runs
// directed requests, a number of random phases at different register settings
// and idle mixes, and a long run of fast ticks at the full-width seconds period.
// ----------------------------------------------------------------------------
module tb_digit_led_matrix_scan_controller;
  import dlms_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED     = 2'd3;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              SETTLE_CYCLES  = 8;

  class scan_scoreboard;
    logic [TPS_W-1:0]  ticks_per_sec;
    logic [RPS_W-1:0]  refresh_period;
    logic [SCR_W-1:0]  scroll_span;

    logic [LINE_W-1:0] digit_line;
    logic [TPS_W-1:0]  tick_count;
    logic [BCD_W-1:0]  seconds;
    bit                digits_on;
    logic [BYTE_W-1:0] led_byte;
    logic [2:0]        led_next;
    logic [LINE_W-1:0] matrix_row;
    logic [SCR_W-1:0]  scroll_offset;
    logic [RPS_W-1:0]  refresh_count;
    logic [BYTE_W-1:0] image_rows [IMAGE_DEPTH];
    logic [BYTE_W-1:0] seg_lut [10];

    line_res_t expected_lines[$];
    int        failures;

    function new();
      ticks_per_sec  = TPS_RESET;
      refresh_period = RPS_RESET;
      scroll_span    = SCR_RESET;
      digit_line     = '0;
      tick_count     = '0;
      seconds        = '0;
      digits_on      = 1'b0;
      led_byte       = 8'hFF;
      led_next       = '0;
      matrix_row     = '0;
      scroll_offset  = '0;
      refresh_count  = '0;
      for (int i = 0; i < IMAGE_DEPTH; i++) image_rows[i] = 8'hFF;
      seg_lut = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
      failures = 0;
    endfunction

    // a zero period means the counter runs the full width before wrapping
    function bit period_hit(input int nx, input int period);
      return (period == 0) ? (nx == 0) : (nx >= period);
    endfunction

    function void seconds_step();
      int sum;
      int carry;
      carry = 1;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        sum = int'(seconds[4*k +: 4]) + carry;
        if (sum >= 10) begin
          sum = 0;
          carry = 1;
        end else begin
          carry = 0;
        end
        seconds[4*k +: 4] = 4'(sum);
      end
    endfunction

    function void set_config(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
      case (idx)
        REG_TICKS_PER_SEC:  ticks_per_sec  = val[TPS_W-1:0];
        REG_REFRESH_PER_SC: refresh_period = val[RPS_W-1:0];
        REG_SCROLL_POS:     scroll_span    = val[SCR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] data);
      line_res_t         res;
      logic [3:0]        dg;
      logic [TPS_W-1:0]  tick_nx;
      logic [RPS_W-1:0]  refresh_nx;
      logic [SCR_W-1:0]  offset_nx;
      case (op)
        OP_FAST: begin
          res.bank = BANK_DIGIT;
          res.line = digit_line;
          dg = seconds[4*digit_line +: 4];
          if (digit_line >= DIGIT_LAST) res.pattern = led_byte;
          else if (digits_on) res.pattern = seg_lut[(dg > 4'd9) ? 4'd9 : dg];
          else res.pattern = BLANK;
          expected_lines.push_back(res);
          digit_line = (digit_line >= DIGIT_LAST) ? '0 : digit_line + 1'b1;
          tick_nx = tick_count + 1'b1;
          if (period_hit(tick_nx, ticks_per_sec)) begin
            tick_count = '0;
            seconds_step();
            digits_on = 1'b1;
            led_byte  = ~(8'd1 << led_next);
            led_next  = led_next + 1'b1;
          end else begin
            tick_count = tick_nx;
          end
        end
        OP_SLOW: begin
          res.bank    = BANK_MATRIX;
          res.line    = matrix_row;
          res.pattern = image_rows[(int'(scroll_offset) + int'(matrix_row)) % IMAGE_DEPTH];
          expected_lines.push_back(res);
          matrix_row = matrix_row + 1'b1;
          refresh_nx = refresh_count + 1'b1;
          if (period_hit(refresh_nx, refresh_period)) begin
            refresh_count = '0;
            offset_nx = scroll_offset + 1'b1;
            scroll_offset = period_hit(offset_nx, scroll_span) ? '0 : offset_nx;
          end else begin
            refresh_count = refresh_nx;
          end
        end
        OP_WRITE: begin
          if (addr < IMAGE_DEPTH) image_rows[addr] = data;
        end
        default: ;
      endcase
    endfunction

    function void check_line(input line_res_t got);
      line_res_t want;
      if (expected_lines.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected line: bank %0d line %0d pattern %02h",
                   got.bank, got.line, got.pattern);
        return;
      end
      want = expected_lines.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display({"line mismatch: expected bank %0d line %0d pattern %02h, ",
                    "got bank %0d line %0d pattern %02h"},
                   want.bank, want.line, want.pattern, got.bank, got.line, got.pattern);
      end
    endfunction

    function void check_leftover();
      if (expected_lines.size() != 0) begin
        failures++;
        $display("%0d expected lines never arrived", expected_lines.size());
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = OP_FAST;
  logic [ADDR_W-1:0]   in_image_address = '0;
  logic [BYTE_W-1:0]   in_image_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_bank_select;
  logic [LINE_W-1:0]   out_line_select;
  logic [BYTE_W-1:0]   out_pattern;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [PDATA_W-1:0]  cfg_pwdata = '0;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  scan_scoreboard sb = new();

  digit_led_matrix_scan_controller u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_image_address (in_image_address),
    .in_image_data    (in_image_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bank_select  (out_bank_select),
    .out_line_select  (out_line_select),
    .out_pattern      (out_pattern),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_line('{bank: out_bank_select, line: out_line_select, pattern: out_pattern});
  end

  // count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_image_address <= addr;
    in_image_data    <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, addr, data);
    @(negedge clk);
  endtask

  task automatic send_random();
    int               pick;
    logic [OP_W-1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_FAST;
    else if (pick < 75) op = OP_SLOW;
    else if (pick < 95) op = OP_WRITE;
    else op = OP_IGNORED;
    send_request(op, ADDR_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
  endtask

  // hold off requests until every predicted line is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge with the bus idle
  task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_config(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_scan(input int tps_v, input int rps_v, input int scr_v);
    wait_drained();
    cfg_write(REG_TICKS_PER_SEC, PDATA_W'(tps_v));
    cfg_write(REG_REFRESH_PER_SC, PDATA_W'(rps_v));
    cfg_write(REG_SCROLL_POS, PDATA_W'(scr_v));
  endtask

  task automatic run_random(input int tx, input int rx, input int n);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    repeat (n) send_random();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, default registers: ignored opcode, image corners, window, blank digits
    tx_idle_pct = 29;
    rx_idle_pct = 49;
    send_request(OP_IGNORED, 6'd63, 8'hFF);
    send_request(OP_IGNORED, 6'd0, 8'h00);
    send_request(OP_WRITE, 6'd0, 8'h00);
    send_request(OP_WRITE, 6'd63, 8'h00);
    send_request(OP_WRITE, 6'd1, 8'hAA);
    send_request(OP_WRITE, 6'd7, 8'h55);
    send_request(OP_WRITE, 6'd8, 8'h0F);
    repeat (9) send_request(OP_SLOW, 6'd0, 8'h00);
    repeat (8) send_request(OP_FAST, 6'd63, 8'hFF);

    set_scan(1, 1, 56);
    run_random(29, 49, 100);
    set_scan(1023, 63, 1);
    run_random(29, 49, 80);
    // tick count is now well above the new period, so the next fast tick fires
    set_scan(3, 1, 0);
    run_random(49, 29, 90);
    set_scan(2, 0, 63);
    run_random(49, 29, 90);

    // full-width seconds period: the count has to run through all 1024 values
    set_scan(0, 5, 10);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (1030) send_request(OP_FAST, 6'd0, 8'h00);

    set_scan(7, 5, 10);
    run_random(0, 0, 50);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.check_leftover();
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dlms_pkg.sv
hdl/dlms_image_ram.sv
hdl/dlms_digit_scan.sv
hdl/dlms_matrix_scan.sv
hdl/digit_led_matrix_scan_controller.sv
dv/tb_digit_led_matrix_scan_controller.sv
